/* src/sbhi_pkg.sv */
// Package for the sorted bucket hash insert unit.
// Holds the input and result word types and the status codes; no dependencies.
package sbhi_pkg;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_COLL = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [9:0]  bucket;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [63:0] dist_w0;
        logic [63:0] dist_w1;
        logic [63:0] dist_w2;
        logic [63:0] dist_w3;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  bucket_count;
        logic [63:0] hit_w0;
        logic [63:0] hit_w1;
        logic [63:0] hit_w2;
        logic [63:0] hit_w3;
    } out_word_t;

    // One stored entry: key and distance words.
    typedef struct packed {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [63:0] d3;
        logic [63:0] d2;
        logic [63:0] d1;
        logic [63:0] d0;
    } entry_t;

endpackage

/* src/sorted_bucket_hash_insert_unit.sv */
// Sorted bucket hash insert unit, top level.
// Depends on sbhi_pkg; holds the fill-count memory and the entry memory.
//
//   channel | direction | type                | handshake
//   in      | input     | sbhi_pkg::in_word_t  | in_valid / in_ready
//   out     | output    | sbhi_pkg::out_word_t | out_valid / out_ready
//
// One word at a time. The bucket count is read as the word is accepted and
// taken in S_CNT; each scanned entry is read in S_SCAN and compared in S_CHECK,
// and each shifted entry is written one slot up in S_SHIFT. The entry memory
// has one read port and one write port and a registered read. The longest
// insert is one into a full bucket that is scanned to its end; after the result
// handshake the unit returns to idle, where the next word is accepted.
// After reset the fill-count memory is cleared, one bucket per cycle, over all
// BUCKETS buckets; no word is accepted during that pass.
// The result sits in an output register; a stalled output holds the unit
// in its done state until the word is taken, then the next input is accepted.
module sorted_bucket_hash_insert_unit #(
    parameter int BUCKETS      = 1024,
    parameter int BUCKET_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sbhi_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output sbhi_pkg::out_word_t out_word
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int DW = $clog2(BUCKET_DEPTH);
    localparam int CW = $clog2(BUCKET_DEPTH + 1);
    localparam int AW = BW + DW;
    // Each bucket owns a power-of-two stride of slots.
    localparam int SLOTS = BUCKETS * (1 << DW);

    // The bucket index is reduced modulo BUCKETS with a reciprocal multiply;
    // the 20-bit shift keeps the quotient exact for every 10-bit index.
    localparam int RECIP_SH = 20;
    localparam int RECIP    = (BUCKETS < 1024) ? ((1 << RECIP_SH) / BUCKETS + 1) : 1;
    localparam logic [9:0] BKT_DIV = (BUCKETS < 1024) ? 10'(BUCKETS) : 10'd0;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CNT   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_SHIFT = 3'd5;
    localparam logic [2:0] S_SHWR  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // Memories: one count per bucket, one entry per slot.
    logic [CW-1:0]          cnt_mem [BUCKETS];
    sbhi_pkg::entry_t       ent_mem [SLOTS];

    logic [2:0]             state_reg, state_next;
    logic [BW-1:0]          clr_reg, clr_next;
    sbhi_pkg::in_word_t     req_reg;
    logic [BW-1:0]          bkt_reg;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          pos_reg;
    logic [CW-1:0]          idx_reg;
    sbhi_pkg::out_word_t    res_reg;

    logic [CW-1:0]          cnt_rd;
    sbhi_pkg::entry_t       ent_rd;

    // Memory control.
    logic                   ent_re, ent_we, cnt_we;
    logic [AW-1:0]          ent_ra, ent_wa;
    sbhi_pkg::entry_t       ent_wd;
    logic [BW-1:0]          cnt_wa;
    logic [CW-1:0]          cnt_wd;

    logic [BW-1:0]          in_bkt;
    logic [29:0]            bkt_prod;
    logic [9:0]             bkt_quo;
    logic [9:0]             bkt_rem;
    logic                   key_lt, key_eq, dist_eq;
    sbhi_pkg::entry_t       new_ent;

    always_comb
    begin
        bkt_prod = 30'(in_word.bucket) * 30'(RECIP);
        bkt_quo  = bkt_prod[29:20];
        bkt_rem  = in_word.bucket - 10'(bkt_quo * BKT_DIV);
        in_bkt   = (BUCKETS < 1024) ? BW'(bkt_rem) : BW'(in_word.bucket);
    end

    function automatic logic [AW-1:0] slot(input logic [BW-1:0] b, input logic [CW-1:0] i);
        slot = AW'({b, i[DW-1:0]});
    endfunction

    assign new_ent = '{key_hi: req_reg.key_hi, key_lo: req_reg.key_lo,
                       d3: req_reg.dist_w3, d2: req_reg.dist_w2,
                       d1: req_reg.dist_w1, d0: req_reg.dist_w0};

    assign key_lt  = (ent_rd.key_hi < req_reg.key_hi) ||
                     ((ent_rd.key_hi == req_reg.key_hi) && (ent_rd.key_lo < req_reg.key_lo));
    assign key_eq  = (ent_rd.key_hi == req_reg.key_hi) && (ent_rd.key_lo == req_reg.key_lo);
    assign dist_eq = (ent_rd.d0 == req_reg.dist_w0) && (ent_rd.d1 == req_reg.dist_w1) &&
                     (ent_rd.d2 == req_reg.dist_w2) && (ent_rd.d3 == req_reg.dist_w3);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_word  = res_reg;

    // Sequencer. Scan reads slot pos; S_CHECK sees that read's data.
    // Shift reads slot idx-1 then writes it to idx, walking down to pos.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ent_re     = 1'b0;
        ent_ra     = slot(bkt_reg, pos_reg);
        ent_we     = 1'b0;
        ent_wa     = slot(bkt_reg, idx_reg);
        ent_wd     = ent_rd;
        cnt_we     = 1'b0;
        cnt_wa     = bkt_reg;
        cnt_wd     = cnt_reg + CW'(1);
        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we = 1'b1;
                cnt_wa = clr_reg;
                cnt_wd = '0;
                clr_next = clr_reg + BW'(1);
                if (32'(clr_reg) == BUCKETS - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
                if (in_valid)
                    state_next = S_CNT;
            S_CNT:
                state_next = S_SCAN;
            S_SCAN:
            begin
                if (pos_reg < cnt_reg)
                begin
                    ent_re = 1'b1;
                    state_next = S_CHECK;
                end
                else if (cnt_reg == CW'(BUCKET_DEPTH))
                    state_next = S_DONE;
                else if (idx_reg == pos_reg)
                    state_next = S_SHWR;
                else
                begin
                    ent_re = 1'b1;
                    ent_ra = slot(bkt_reg, idx_reg - CW'(1));
                    state_next = S_SHIFT;
                end
            end
            S_CHECK:
                if (key_lt)
                    state_next = S_SCAN;
                else if (key_eq)
                    state_next = S_DONE;
                else if (cnt_reg == CW'(BUCKET_DEPTH))
                    state_next = S_DONE;
                else if (idx_reg == pos_reg)
                    state_next = S_SHWR;
                else
                begin
                    ent_re = 1'b1;
                    ent_ra = slot(bkt_reg, idx_reg - CW'(1));
                    state_next = S_SHIFT;
                end
            S_SHIFT:
            begin
                ent_we = 1'b1;
                if (idx_reg - CW'(1) == pos_reg)
                    state_next = S_SHWR;
                else
                begin
                    ent_re = 1'b1;
                    ent_ra = slot(bkt_reg, idx_reg - CW'(2));
                end
            end
            S_SHWR:
            begin
                ent_we = 1'b1;
                ent_wd = new_ent;
                cnt_we = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_wa] <= ent_wd;
        if (ent_re)
            ent_rd <= ent_mem[ent_ra];
        if (cnt_we)
            cnt_mem[cnt_wa] <= cnt_wd;
        cnt_rd <= cnt_mem[in_bkt];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    req_reg <= in_word;
                    bkt_reg <= in_bkt;
                    pos_reg <= '0;
                end
            S_CNT:
            begin
                cnt_reg <= cnt_rd;
                idx_reg <= cnt_rd;
                res_reg <= '{status: sbhi_pkg::ST_OK, bucket_count: 5'(cnt_rd),
                             hit_w0: '0, hit_w1: '0, hit_w2: '0, hit_w3: '0};
            end
            S_SCAN:
                if (!(pos_reg < cnt_reg) && cnt_reg == CW'(BUCKET_DEPTH))
                    res_reg.status <= sbhi_pkg::ST_FULL;
            S_CHECK:
                if (key_lt)
                    pos_reg <= pos_reg + CW'(1);
                else if (key_eq)
                begin
                    if (dist_eq)
                        res_reg.status <= sbhi_pkg::ST_DUP;
                    else
                    begin
                        res_reg.status <= sbhi_pkg::ST_COLL;
                        res_reg.hit_w0 <= ent_rd.d0;
                        res_reg.hit_w1 <= ent_rd.d1;
                        res_reg.hit_w2 <= ent_rd.d2;
                        res_reg.hit_w3 <= ent_rd.d3;
                    end
                end
                else if (cnt_reg == CW'(BUCKET_DEPTH))
                    res_reg.status <= sbhi_pkg::ST_FULL;
            S_SHIFT:
                idx_reg <= idx_reg - CW'(1);
            S_SHWR:
                res_reg.bucket_count <= 5'(cnt_reg + CW'(1));
            default:
            begin
            end
        endcase
    end

endmodule

/* src/sbhi_checker.sv */
// Port-level checker for the sorted bucket hash insert unit.
// Depends on sbhi_pkg; bound to sorted_bucket_hash_insert_unit below.
module sbhi_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input sbhi_pkg::out_word_t out_word
);

    // Output word stays put while stalled.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // One word at a time: no input taken while a result waits.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // Non-collision results carry zero hit words (checked on hit_w0 and hit_w3).
    a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.status != sbhi_pkg::ST_COLL |->
        out_word.hit_w0 == '0 && out_word.hit_w3 == '0)
        else $error("hit words nonzero without collision");

    // Inserts that return OK leave a nonzero bucket count.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.status == sbhi_pkg::ST_OK |-> out_word.bucket_count != 5'd0)
        else $error("insert reported empty bucket");

endmodule

bind sorted_bucket_hash_insert_unit sbhi_checker u_sbhi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

/* tb/sv/sorted_bucket_hash_insert_unit_test.sv */
// Testbench for the sorted bucket hash insert unit.
// Depends on sbhi_pkg and sorted_bucket_hash_insert_unit; checks every result word
// against a behavioral table model kept inside this module.
`timescale 1ns / 1ps

module sorted_bucket_hash_insert_unit_test;

    localparam int BUCKETS = 1024;
    localparam int DEPTH = 16;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid = 1'b0;
    logic in_ready;
    sbhi_pkg::in_word_t in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    sbhi_pkg::out_word_t out_word;

    sorted_bucket_hash_insert_unit #(
        .BUCKETS(BUCKETS),
        .BUCKET_DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word(out_word)
    );

    // Shadow copy of the table. Only the buckets the stimulus touches get entries,
    // so the entry store is an associative array keyed by bucket.
    int table_fill [BUCKETS] = '{default: 0};
    sbhi_pkg::entry_t table_rows [int][$];

    sbhi_pkg::in_word_t pending_words[$];
    sbhi_pkg::out_word_t expected_results[$];
    int mismatches = 0;
    int results_seen = 0;
    int collisions_seen = 0;
    int fulls_seen = 0;
    int dups_seen = 0;
    longint cycle_count = 0;
    bit hold_off_request = 1'b0;
    bit hold_off_done = 1'b0;
    int hold_off_cycles = 0;
    bit drain_request = 1'b0;
    bit drain_done = 1'b0;
    int send_gap = 0;
    bit sent_last = 1'b0;
    int stall_left = 0;

    // Small pool of buckets keeps keys colliding and buckets filling.
    int hot_buckets[6] = '{0, 1, 511, 1023, 37, 700};
    logic [63:0] recent_hi[$];
    logic [63:0] recent_lo[$];

    always #10 clk = ~clk;

    // Predict one insert: walk the bucket in ascending key order and find
    // the first stored key that is not below the new key.
    function automatic sbhi_pkg::out_word_t predict_insert(sbhi_pkg::in_word_t w);
        sbhi_pkg::out_word_t r;
        int b;
        int n;
        int pos;
        sbhi_pkg::entry_t e;
        sbhi_pkg::entry_t row[$];
        b = int'(w.bucket) % BUCKETS;
        n = table_fill[b];
        if (table_rows.exists(b))
            row = table_rows[b];
        r = '0;
        pos = 0;
        while (pos < n && {row[pos].key_hi, row[pos].key_lo} < {w.key_hi, w.key_lo})
            pos++;
        if (pos < n && row[pos].key_hi == w.key_hi && row[pos].key_lo == w.key_lo)
        begin
            if (row[pos].d0 == w.dist_w0 && row[pos].d1 == w.dist_w1 &&
                row[pos].d2 == w.dist_w2 && row[pos].d3 == w.dist_w3)
                r.status = sbhi_pkg::ST_DUP;
            else
            begin
                r.status = sbhi_pkg::ST_COLL;
                r.hit_w0 = row[pos].d0;
                r.hit_w1 = row[pos].d1;
                r.hit_w2 = row[pos].d2;
                r.hit_w3 = row[pos].d3;
            end
        end
        else if (n >= DEPTH)
        begin
            r.status = sbhi_pkg::ST_FULL;
        end
        else
        begin
            e.key_hi = w.key_hi;
            e.key_lo = w.key_lo;
            e.d0 = w.dist_w0;
            e.d1 = w.dist_w1;
            e.d2 = w.dist_w2;
            e.d3 = w.dist_w3;
            row.insert(pos, e);
            table_rows[b] = row;
            n++;
            table_fill[b] = n;
            r.status = sbhi_pkg::ST_OK;
        end
        r.bucket_count = 5'(n);
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Build one insert word. Keys are often drawn from a short list of recent
    // keys so that duplicates and collisions occur; distances are often
    // tiny so duplicates are likely too.
    function automatic sbhi_pkg::in_word_t make_word(int mode);
        sbhi_pkg::in_word_t w;
        int k;
        w.bucket = (mode == 0) ? 10'($urandom) : 10'(hot_buckets[$urandom_range(0, 5)]);
        if (mode != 0 && recent_hi.size() > 0 && $urandom_range(0, 2) == 0)
        begin
            k = $urandom_range(0, recent_hi.size() - 1);
            w.key_hi = recent_hi[k];
            w.key_lo = recent_lo[k];
        end
        else
        begin
            w.key_hi = ($urandom_range(0, 1) == 1) ? rand64() : 64'($urandom_range(0, 3));
            w.key_lo = rand64();
            recent_hi.push_back(w.key_hi);
            recent_lo.push_back(w.key_lo);
            if (recent_hi.size() > 12)
            begin
                void'(recent_hi.pop_front());
                void'(recent_lo.pop_front());
            end
        end
        if ($urandom_range(0, 1) == 1)
        begin
            w.dist_w0 = 64'($urandom_range(0, 1));
            w.dist_w1 = 64'h0;
            w.dist_w2 = 64'h0;
            w.dist_w3 = 64'h0;
        end
        else
        begin
            w.dist_w0 = rand64();
            w.dist_w1 = rand64();
            w.dist_w2 = rand64();
            w.dist_w3 = rand64();
        end
        return w;
    endfunction

    // Driver: words change only on the falling edge. Valid stays up until
    // the word is taken, and after each taken word a random send_gap is counted down.
    // Once a drain is requested the driver sits still, with valid low,
    // until every expected result has come back.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && sent_last)
            begin
                in_valid <= 1'b0;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            end
            else if (!in_valid)
            begin
                if (drain_request && !drain_done)
                begin
                    if (expected_results.size() == 0)
                        drain_done <= 1'b1;
                end
                else if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (pending_words.size() > 0)
                begin
                    in_word <= pending_words[0];
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Acceptance of an input word: predict here, at the rising edge.
    always @(posedge clk)
    begin
        sent_last <= 1'b0;
        if (rst_n && in_valid && in_ready)
        begin
            expected_results.push_back(predict_insert(in_word));
            void'(pending_words.pop_front());
            sent_last <= 1'b1;
        end
    end

    // Receiver readiness: a random stall after each taken word, plus one long
    // hold-off, counted here, that lets the unit back up.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off_request && !hold_off_done)
        begin
            hold_off_done <= 1'b1;
            hold_off_cycles <= 400;
            out_ready <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= (hold_off_cycles == 1);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= (stall_left == 1);
        end
        else if (out_ready && out_valid)
        begin
            stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        sbhi_pkg::out_word_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %h", out_word);
            end
            else
            begin
                exp_w = expected_results.pop_front();
                case (exp_w.status)
                    sbhi_pkg::ST_DUP: dups_seen++;
                    sbhi_pkg::ST_COLL: collisions_seen++;
                    sbhi_pkg::ST_FULL: fulls_seen++;
                    default: ;
                endcase
                if (out_word.status !== exp_w.status ||
                    out_word.bucket_count !== exp_w.bucket_count ||
                    out_word.hit_w0 !== exp_w.hit_w0 || out_word.hit_w1 !== exp_w.hit_w1 ||
                    out_word.hit_w2 !== exp_w.hit_w2 || out_word.hit_w3 !== exp_w.hit_w3)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at result %0d: expected %h, got %h",
                                 results_seen, exp_w, out_word);
                end
            end
        end
    end

    // Watchdog on total cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        sbhi_pkg::in_word_t w;
        int i;
        rst_n = 1'b0;

        // Directed words: extreme keys and buckets, a duplicate, a collision,
        // then a bucket filled to its depth with a key hit while full.
        w = '0;
        pending_words.push_back(w);
        w = '1;
        pending_words.push_back(w);
        pending_words.push_back(w);
        w.dist_w2 = 64'h0;
        pending_words.push_back(w);
        w = '0;
        w.bucket = 10'd5;
        w.key_hi = 64'h1;
        pending_words.push_back(w);
        w.key_hi = 64'h0;
        w.key_lo = '1;
        pending_words.push_back(w);
        w.key_lo = 64'h0;
        pending_words.push_back(w);
        for (i = 0; i < 15; i++)
        begin
            w = '0;
            w.bucket = 10'd9;
            w.key_hi = 64'(100 - 3 * i);
            w.key_lo = 64'(i);
            w.dist_w1 = 64'h8000_0000_0000_0000;
            pending_words.push_back(w);
        end
        w.key_hi = 64'd1;
        pending_words.push_back(w);
        w.key_hi = 64'd58;
        w.key_lo = 64'd14;
        w.dist_w0 = 64'd7;
        pending_words.push_back(w);

        // Random words, mostly aimed at a few buckets.
        for (i = 0; i < 480; i++)
            pending_words.push_back(make_word($urandom_range(0, 3) == 0 ? 0 : 1));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Once part way through, stop reading results for a long stretch, and
        // later make the sender wait until every expectation is met.
        wait (pending_words.size() < 400);
        @(negedge clk);
        hold_off_request = 1'b1;
        wait (pending_words.size() < 200);
        @(negedge clk);
        drain_request = 1'b1;

        wait (pending_words.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (60) @(posedge clk);

        $display("Ran %0d insert words: %0d duplicates, %0d collisions, %0d full buckets.",
                 results_seen, dups_seen, collisions_seen, fulls_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sorted_bucket_hash_insert_unit.f */
src/sbhi_pkg.sv
src/sorted_bucket_hash_insert_unit.sv
src/sbhi_checker.sv
tb/sv/sorted_bucket_hash_insert_unit_test.sv
